// ===== hdl/omux_pkg.sv =====
// Shared types and constants for the owned command multiplexer.
// No dependencies; every other file in hdl/ refers to this package.
package omux_pkg;

    localparam int NUM_SOURCES   = 3;
    localparam int TIME_BITS     = 32;
    localparam int VALUE_BITS    = 32;
    localparam int TYPE_BITS     = 3;
    localparam int SRC_BITS      = 2;
    localparam int CODE_BITS     = 3;
    localparam int OWNER_BITS    = 2;
    localparam int KIND_BITS     = 2;
    localparam int IDX_BITS      = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [TIME_BITS-1:0] TIMEOUT_RESET = 32'd500000;
    localparam logic [TIME_BITS-1:0] SKEW_RESET    = 32'd150000;

    typedef logic [OWNER_BITS-1:0] owner_t;
    localparam owner_t OWNER_IDLE = '0;

    typedef enum logic [TYPE_BITS-1:0] {
        REQ_CMD  = 3'd0,
        REQ_ART  = 3'd1,
        REQ_GRAB = 3'd2,
        REQ_DROP = 3'd3,
        REQ_TICK = 3'd4
    } req_type_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_FWD     = 2'd0,
        KIND_ZERO    = 2'd1,
        KIND_CHANGED = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_INPUT_TIMEOUT = 1'b0,
        CFG_MAX_PAIR_SKEW = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [TYPE_BITS-1:0]         req_type;
        logic [SRC_BITS-1:0]          source;
        logic [CODE_BITS-1:0]         owner_code;
        logic signed [VALUE_BITS-1:0] linear_x;
        logic signed [VALUE_BITS-1:0] angular_z;
        logic signed [VALUE_BITS-1:0] articulation;
        logic                         value_bad;
        logic [TIME_BITS-1:0]         now_time;
    } cmd_item_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]         kind;
        logic signed [VALUE_BITS-1:0] out_linear_x;
        logic signed [VALUE_BITS-1:0] out_angular_z;
        logic signed [VALUE_BITS-1:0] out_articulation;
        owner_t                       current_owner;
        logic [TIME_BITS-1:0]         stamp;
        logic                         last_result;
    } res_item_t;

    // Write side of the per-source store and owner register
    typedef struct packed {
        logic                  wr_cmd;
        logic                  wr_art;
        logic [IDX_BITS-1:0]   idx;
        logic [VALUE_BITS-1:0] lin;
        logic [VALUE_BITS-1:0] ang;
        logic [VALUE_BITS-1:0] art;
        logic [TIME_BITS-1:0]  rx_time;
        logic                  own_we;
        owner_t                own_next;
    } store_upd_t;

    // Held state of the current owner's source
    typedef struct packed {
        logic                  has_cmd;
        logic                  has_art;
        logic [VALUE_BITS-1:0] lin;
        logic [VALUE_BITS-1:0] ang;
        logic [VALUE_BITS-1:0] art;
        logic [TIME_BITS-1:0]  cmd_time;
        logic [TIME_BITS-1:0]  art_time;
    } store_view_t;

endpackage

// ===== hdl/omux_if.sv =====
// Valid/ready channel interfaces for command items and result items.
// Depends on omux_pkg for the payload types.
interface omux_cmd_if;
    logic                  valid;
    logic                  ready;
    omux_pkg::cmd_item_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface omux_res_if;
    logic                  valid;
    logic                  ready;
    omux_pkg::res_item_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/omux_store.sv =====
// Per-source held samples, receive times, held flags and the owner register.
// Depends on omux_pkg.
module omux_store (
    input  logic                   clk,
    input  logic                   rst_n,
    input  omux_pkg::store_upd_t   upd,
    output omux_pkg::owner_t       owner,
    output omux_pkg::store_view_t  view
);

    logic [omux_pkg::VALUE_BITS-1:0] lin_reg  [omux_pkg::NUM_SOURCES];
    logic [omux_pkg::VALUE_BITS-1:0] ang_reg  [omux_pkg::NUM_SOURCES];
    logic [omux_pkg::VALUE_BITS-1:0] art_reg  [omux_pkg::NUM_SOURCES];
    logic [omux_pkg::TIME_BITS-1:0]  ctime_reg [omux_pkg::NUM_SOURCES];
    logic [omux_pkg::TIME_BITS-1:0]  atime_reg [omux_pkg::NUM_SOURCES];

    logic [omux_pkg::NUM_SOURCES-1:0] has_cmd_reg;
    logic [omux_pkg::NUM_SOURCES-1:0] has_cmd_next;
    logic [omux_pkg::NUM_SOURCES-1:0] has_art_reg;
    logic [omux_pkg::NUM_SOURCES-1:0] has_art_next;
    omux_pkg::owner_t                 owner_reg;
    omux_pkg::owner_t                 owner_next;

    logic [omux_pkg::IDX_BITS-1:0]    sel;
    logic [omux_pkg::IDX_BITS-1:0]    clr_idx;

    assign clr_idx = omux_pkg::IDX_BITS'(upd.own_next - 1'b1);

    always_comb
    begin
        has_cmd_next = has_cmd_reg;
        has_art_next = has_art_reg;
        if (upd.wr_cmd)
        begin
            has_cmd_next[upd.idx] = 1'b1;
        end
        if (upd.wr_art)
        begin
            has_art_next[upd.idx] = 1'b1;
        end
        // A source that just took ownership starts with nothing held
        if (upd.own_we && upd.own_next != omux_pkg::OWNER_IDLE)
        begin
            has_cmd_next[clr_idx] = 1'b0;
            has_art_next[clr_idx] = 1'b0;
        end
        owner_next = upd.own_we ? upd.own_next : owner_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_cmd_reg <= '0;
            has_art_reg <= '0;
            owner_reg   <= omux_pkg::OWNER_IDLE;
        end
        else
        begin
            has_cmd_reg <= has_cmd_next;
            has_art_reg <= has_art_next;
            owner_reg   <= owner_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.wr_cmd)
        begin
            lin_reg[upd.idx]   <= upd.lin;
            ang_reg[upd.idx]   <= upd.ang;
            ctime_reg[upd.idx] <= upd.rx_time;
        end
        if (upd.wr_art)
        begin
            art_reg[upd.idx]   <= upd.art;
            atime_reg[upd.idx] <= upd.rx_time;
        end
    end

    assign sel = (owner_reg != omux_pkg::OWNER_IDLE)
               ? omux_pkg::IDX_BITS'(owner_reg - 1'b1) : '0;

    assign owner         = owner_reg;
    assign view.has_cmd  = has_cmd_reg[sel];
    assign view.has_art  = has_art_reg[sel];
    assign view.lin      = lin_reg[sel];
    assign view.ang      = ang_reg[sel];
    assign view.art      = art_reg[sel];
    assign view.cmd_time = ctime_reg[sel];
    assign view.art_time = atime_reg[sel];

endmodule

// ===== hdl/omux_eval.sv =====
// Decode of one command item: store writes, owner change, staleness check and results.
// Depends on omux_pkg.
module omux_eval (
    input  omux_pkg::cmd_item_t              item,
    input  omux_pkg::owner_t                 owner,
    input  omux_pkg::store_view_t            view,
    input  logic [omux_pkg::TIME_BITS-1:0]   input_timeout,
    input  logic [omux_pkg::TIME_BITS-1:0]   max_pair_skew,
    output omux_pkg::store_upd_t             upd,
    output logic [1:0]                       res_cnt,
    output omux_pkg::res_item_t              res0,
    output omux_pkg::res_item_t              res1
);

    logic [omux_pkg::TIME_BITS-1:0] cmd_age;
    logic [omux_pkg::TIME_BITS-1:0] art_age;
    logic [omux_pkg::TIME_BITS-1:0] diff_ca;
    logic [omux_pkg::TIME_BITS-1:0] diff_ac;
    logic [omux_pkg::TIME_BITS-1:0] skew;
    logic                           fresh;
    logic                           src_ok;
    logic                           code_src;
    logic                           code_is_owner;
    logic                           is_tick;
    omux_pkg::owner_t               new_owner;

    assign cmd_age = item.now_time - view.cmd_time;
    assign art_age = item.now_time - view.art_time;
    assign diff_ca = view.cmd_time - view.art_time;
    assign diff_ac = view.art_time - view.cmd_time;
    assign skew    = diff_ca[omux_pkg::TIME_BITS-1] ? diff_ac : diff_ca;

    assign fresh = view.has_cmd && view.has_art
                && (cmd_age <= input_timeout) && (art_age <= input_timeout)
                && (skew <= max_pair_skew);

    assign src_ok = !item.value_bad
                 && (item.source < omux_pkg::SRC_BITS'(omux_pkg::NUM_SOURCES));
    assign code_src = (item.owner_code != '0)
                   && (item.owner_code <= omux_pkg::CODE_BITS'(omux_pkg::NUM_SOURCES));
    assign code_is_owner = (item.owner_code == omux_pkg::CODE_BITS'(owner));

    always_comb
    begin
        upd          = '0;
        upd.idx      = omux_pkg::IDX_BITS'(item.source);
        upd.lin      = item.linear_x;
        upd.ang      = item.angular_z;
        upd.art      = item.articulation;
        upd.rx_time  = item.now_time;
        upd.own_next = omux_pkg::OWNER_IDLE;
        res_cnt      = 2'd0;
        is_tick      = 1'b0;

        case (item.req_type)
            omux_pkg::REQ_CMD:
            begin
                upd.wr_cmd = src_ok;
            end
            omux_pkg::REQ_ART:
            begin
                upd.wr_art = src_ok;
            end
            omux_pkg::REQ_GRAB:
            begin
                if (code_src && !code_is_owner)
                begin
                    upd.own_we   = 1'b1;
                    upd.own_next = omux_pkg::OWNER_BITS'(item.owner_code);
                    res_cnt      = 2'd2;
                end
            end
            omux_pkg::REQ_DROP:
            begin
                // Releasing idle while idle still sends a zero command
                if (code_is_owner)
                begin
                    if (owner != omux_pkg::OWNER_IDLE)
                    begin
                        upd.own_we = 1'b1;
                        res_cnt    = 2'd2;
                    end
                    else
                    begin
                        res_cnt = 2'd1;
                    end
                end
            end
            omux_pkg::REQ_TICK:
            begin
                if (owner != omux_pkg::OWNER_IDLE)
                begin
                    res_cnt = 2'd1;
                    is_tick = 1'b1;
                end
            end
            default:
            begin
                res_cnt = 2'd0;
            end
        endcase

        new_owner = upd.own_we ? upd.own_next : owner;

        res0               = '0;
        res0.kind          = omux_pkg::KIND_ZERO;
        res0.current_owner = new_owner;
        res0.stamp         = item.now_time;
        res0.last_result   = 1'b1;
        res1               = res0;

        if (res_cnt == 2'd2)
        begin
            res0.kind        = omux_pkg::KIND_CHANGED;
            res0.last_result = 1'b0;
        end
        else if (is_tick && fresh)
        begin
            res0.kind             = omux_pkg::KIND_FWD;
            res0.out_linear_x     = view.lin;
            res0.out_angular_z    = view.ang;
            res0.out_articulation = view.art;
        end
    end

endmodule

// ===== hdl/omux_res_fifo.sv =====
// Four-entry result queue that takes up to two results per cycle and delivers one per cycle while res.ready is high.
// Depends on omux_pkg and omux_res_if.
module omux_res_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [1:0]              push_cnt,
    input  omux_pkg::res_item_t     push0,
    input  omux_pkg::res_item_t     push1,
    output logic [2:0]              free,
    omux_res_if.source              res
);

    localparam int DEPTH    = 4;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = PTR_BITS + 1;

    omux_pkg::res_item_t mem_reg [DEPTH];

    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] wr_ptr_plus;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                pop;

    assign pop         = res.valid && res.ready;
    assign wr_ptr_plus = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + PTR_BITS'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
    assign count_next  = count_reg + CNT_BITS'(push_cnt) - CNT_BITS'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_plus] <= push1;
        end
    end

    assign free      = 3'(CNT_BITS'(DEPTH) - count_reg);
    assign res.valid = (count_reg != '0);
    assign res.data  = mem_reg[rd_ptr_reg];

endmodule

// ===== hdl/owned_command_mux_with_staleness_check_core.sv =====
// Top level of the owned command multiplexer with staleness watchdog.
// Depends on omux_pkg, omux_if, omux_store, omux_eval and omux_res_fifo.
//
// An accepted item lands in an input register and is decoded there against the owner
// register and the per-source store; once the queue has room for all of its results, the
// store and owner are updated and its zero, one or two results are pushed into a
// four-entry result queue whose head drives res. One item is taken per cycle as long
// as the queue has room for the results of the item in the input register; the queue
// drains one result per cycle while res.ready is high, so a steady stream of items that
// each cause two results is limited by the drain of the queue. Configuration writes on
// cfg_we take effect at the next edge.
module owned_command_mux_with_staleness_check_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    omux_cmd_if.sink                             cmd,
    omux_res_if.source                           res,
    input  logic                                 cfg_we,
    input  logic [omux_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [omux_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    omux_pkg::cmd_item_t             item_reg;
    logic                            item_valid_reg;
    logic                            item_valid_next;
    logic                            advance;

    logic [omux_pkg::TIME_BITS-1:0]  timeout_reg;
    logic [omux_pkg::TIME_BITS-1:0]  skew_reg;

    omux_pkg::owner_t                owner;
    omux_pkg::store_view_t           view;
    omux_pkg::store_upd_t            upd;
    omux_pkg::store_upd_t            upd_gated;
    logic [1:0]                      res_cnt;
    logic [1:0]                      push_cnt;
    omux_pkg::res_item_t             res0;
    omux_pkg::res_item_t             res1;
    logic [2:0]                      free;

    // Hold the item until the queue can absorb all of its results
    assign advance         = item_valid_reg && (free >= {1'b0, res_cnt});
    assign cmd.ready       = !item_valid_reg || advance;
    assign item_valid_next = (cmd.valid && cmd.ready) || (item_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            item_reg <= cmd.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= omux_pkg::TIMEOUT_RESET;
            skew_reg    <= omux_pkg::SKEW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                omux_pkg::CFG_INPUT_TIMEOUT:
                begin
                    timeout_reg <= omux_pkg::TIME_BITS'(cfg_data);
                end
                omux_pkg::CFG_MAX_PAIR_SKEW:
                begin
                    skew_reg <= omux_pkg::TIME_BITS'(cfg_data);
                end
                default:
                begin
                    timeout_reg <= timeout_reg;
                end
            endcase
        end
    end

    omux_eval u_eval (
        .item          (item_reg),
        .owner         (owner),
        .view          (view),
        .input_timeout (timeout_reg),
        .max_pair_skew (skew_reg),
        .upd           (upd),
        .res_cnt       (res_cnt),
        .res0          (res0),
        .res1          (res1)
    );

    // Drop store writes and pushes while the item is held
    assign upd_gated = advance ? upd : '0;
    assign push_cnt  = advance ? res_cnt : 2'd0;

    omux_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd_gated),
        .owner (owner),
        .view  (view)
    );

    omux_res_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push0    (res0),
        .push1    (res1),
        .free     (free),
        .res      (res)
    );

endmodule

// ===== hdl/omux_checker.sv =====
// Port-level checks on the result channel of the command multiplexer, bound to the top level.
// Depends on omux_pkg and owned_command_mux_with_staleness_check_core.
module omux_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  logic                 res_ready,
    input  omux_pkg::res_item_t  res_data
);

    // A stalled result holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
        else $error("result changed while stalled");

    // The zero command that follows an owner change is queued with it
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && !res_data.last_result) |=> res_valid)
        else $error("second result of an item missing");

    // Only an owner change is a non-final result
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_data.kind == omux_pkg::KIND_CHANGED) != res_data.last_result))
        else $error("last_result inconsistent with kind");

    // A forwarded command always comes from an owning source
    a_fwd_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.kind == omux_pkg::KIND_FWD)
            |-> (res_data.current_owner != omux_pkg::OWNER_IDLE))
        else $error("forwarded command while idle");

endmodule

bind owned_command_mux_with_staleness_check_core omux_checker u_omux_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
);
